// ===== rtl/scm_pkg.sv =====
// Shared types, constants and a helper function for the scalar colormap blend block.
package scm_pkg;

   localparam int FRAC_W = 16;
   localparam int QUO_W = FRAC_W + 1;
   localparam int REM_W = 25;
   localparam logic [QUO_W-1:0] ONE_Q16 = 17'h10000;

   localparam int MAX_STOPS_DEF = 16;
   localparam int NUM_PALETTES_DEF = 4;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] REG_NORM_MODE = 3'd0;
   localparam logic [2:0] REG_SLAB_LOW = 3'd1;
   localparam logic [2:0] REG_SLAB_HIGH = 3'd2;
   localparam logic [2:0] REG_RADIUS = 3'd3;
   localparam logic [2:0] REG_PALETTE_SELECT = 3'd4;
   localparam logic [2:0] REG_COMBINE_ENABLE = 3'd5;
   localparam logic [2:0] REG_BLEND_ALPHA = 3'd6;

   localparam logic [1:0] PAL_MONO = 2'd0;
   localparam logic [1:0] PAL_RGB = 2'd1;
   localparam logic [1:0] PAL_RAINBOW = 2'd2;
   localparam logic [1:0] PAL_GEO = 2'd3;

   localparam logic OP_MAP = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [23:0] SLAB_HIGH_RESET = 24'h010000;
   localparam logic [22:0] RADIUS_RESET = 23'h010000;
   localparam logic [8:0] ALPHA_ONE = 9'd256;

   typedef struct packed {
      logic       op;
      logic [7:0] old_red;
      logic [7:0] old_green;
      logic [7:0] old_blue;
      logic [1:0] stop_palette;
      logic [3:0] stop_index;
      logic [7:0] stop_red;
      logic [7:0] stop_green;
      logic [7:0] stop_blue;
   } item_type;

   localparam int ITEM_W = $bits(item_type);

   function automatic logic [4:0] stop_count(logic [1:0] pal);
      logic [4:0] n;
      case (pal)
         PAL_MONO: n = 5'd2;
         PAL_RGB: n = 5'd3;
         PAL_RAINBOW: n = 5'd6;
         default: n = 5'd11;
      endcase
      return n;
   endfunction

endpackage

// ===== rtl/scalar_colormap_blend.sv =====
// Top level of the scalar colormap blend pipeline with its register file and palette memory.
//
//   Channel   Ports       Direction  Moves
//   req       req_*       in         one request: map a scalar or write a palette stop
//   rsp       rsp_*       out        one RGB result per map request
//   csr       p*          in/out     APB-style register access
//
// One request enters per cycle while req_ready is high; the divider has 17 stages.
// Reset is synchronous and resets valid bits and config registers; the palette memory is not cleared.
// A stall on rsp backs up stage by stage, so bubbles are squeezed out before req stalls.
// Stop writes update the memory at the read stage, in order with map requests.
module scalar_colormap_blend #(
   parameter int MAX_STOPS = scm_pkg::MAX_STOPS_DEF,
   parameter int NUM_PALETTES = scm_pkg::NUM_PALETTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_opcode,
   input  logic signed [23:0]                req_scalar_value,
   input  logic [7:0]                        req_old_red,
   input  logic [7:0]                        req_old_green,
   input  logic [7:0]                        req_old_blue,
   input  logic [1:0]                        req_stop_palette,
   input  logic [3:0]                        req_stop_index,
   input  logic [7:0]                        req_stop_red,
   input  logic [7:0]                        req_stop_green,
   input  logic [7:0]                        req_stop_blue,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_red,
   output logic [7:0]                        rsp_green,
   output logic [7:0]                        rsp_blue,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [scm_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [scm_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [scm_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   localparam int DEPTH = NUM_PALETTES * MAX_STOPS;
   localparam int AW = $clog2(DEPTH);
   localparam int SW = $clog2(MAX_STOPS);
   localparam int PAL_MAX = NUM_PALETTES - 1;
   localparam int QW = scm_pkg::QUO_W;
   localparam int RW = scm_pkg::REM_W;

   // Configuration registers.
   logic               norm_mode_ff;
   logic signed [23:0] slab_low_ff;
   logic signed [23:0] slab_high_ff;
   logic [22:0]        radius_ff;
   logic [1:0]         palette_select_ff;
   logic               combine_enable_ff;
   logic [8:0]         blend_alpha_ff;
   logic [2:0]         reg_sel;
   logic               csr_write;

   assign pready = 1'b1;
   assign reg_sel = paddr[4:2];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_mode_ff <= 1'b0;
         slab_low_ff <= '0;
         slab_high_ff <= scm_pkg::SLAB_HIGH_RESET;
         radius_ff <= scm_pkg::RADIUS_RESET;
         palette_select_ff <= '0;
         combine_enable_ff <= 1'b0;
         blend_alpha_ff <= scm_pkg::ALPHA_ONE;
      end else if (csr_write) begin
         unique case (reg_sel)
            scm_pkg::REG_NORM_MODE: norm_mode_ff <= pwdata[0];
            scm_pkg::REG_SLAB_LOW: slab_low_ff <= pwdata[23:0];
            scm_pkg::REG_SLAB_HIGH: slab_high_ff <= pwdata[23:0];
            scm_pkg::REG_RADIUS: radius_ff <= pwdata[22:0];
            scm_pkg::REG_PALETTE_SELECT: palette_select_ff <= pwdata[1:0];
            scm_pkg::REG_COMBINE_ENABLE: combine_enable_ff <= pwdata[0];
            scm_pkg::REG_BLEND_ALPHA: blend_alpha_ff <= pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         scm_pkg::REG_NORM_MODE: prdata = 32'(norm_mode_ff);
         scm_pkg::REG_SLAB_LOW: prdata = 32'(unsigned'(slab_low_ff));
         scm_pkg::REG_SLAB_HIGH: prdata = 32'(unsigned'(slab_high_ff));
         scm_pkg::REG_RADIUS: prdata = 32'(radius_ff);
         scm_pkg::REG_PALETTE_SELECT: prdata = 32'(palette_select_ff);
         scm_pkg::REG_COMBINE_ENABLE: prdata = 32'(combine_enable_ff);
         scm_pkg::REG_BLEND_ALPHA: prdata = 32'(blend_alpha_ff);
         default: prdata = '0;
      endcase
   end

   // Palette geometry derived from the static configuration.
   logic [1:0]    pal_eff;
   logic [4:0]    n_raw;
   logic [4:0]    n_cap;
   logic [SW-1:0] s_seg;
   logic [AW-1:0] pal_base;
   logic [8:0]    alpha_eff;

   always_comb begin
      pal_eff = (palette_select_ff > 2'(PAL_MAX)) ? 2'(PAL_MAX) : palette_select_ff;
      n_raw = scm_pkg::stop_count(pal_eff);
      n_cap = (n_raw > 5'(MAX_STOPS)) ? 5'(MAX_STOPS) : n_raw;
      s_seg = SW'(n_cap - 5'd1);
      pal_base = AW'(int'(pal_eff) * MAX_STOPS);
      alpha_eff = (blend_alpha_ff > scm_pkg::ALPHA_ONE) ? scm_pkg::ALPHA_ONE : blend_alpha_ff;
   end

   // Pipeline enables, from the output back.
   logic take_b, take_l, take_m, take_p, take_2, take_1;
   logic div_in_ready, div_out_valid;

   // Stage 1: request register.
   logic                v1_ff;
   logic signed [23:0]  x1_ff;
   scm_pkg::item_type   item1_ff;

   assign take_1 = !v1_ff || take_2;
   assign req_ready = take_1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (take_1) begin
         v1_ff <= req_valid;
      end
      if (take_1) begin
         x1_ff <= req_scalar_value;
         item1_ff.op <= req_opcode;
         item1_ff.old_red <= req_old_red;
         item1_ff.old_green <= req_old_green;
         item1_ff.old_blue <= req_old_blue;
         item1_ff.stop_palette <= req_stop_palette;
         item1_ff.stop_index <= req_stop_index;
         item1_ff.stop_red <= req_stop_red;
         item1_ff.stop_green <= req_stop_green;
         item1_ff.stop_blue <= req_stop_blue;
      end
   end

   // Stage 2: clamp and pick dividend and divisor. Fixed answers become 0/1 or 1/1.
   logic              v2_ff;
   logic [RW-1:0]     num2_ff, num2_in;
   logic [RW-1:0]     den2_ff, den2_in;
   scm_pkg::item_type item2_ff;
   logic signed [24:0] x_ext, low_ext, high_ext, xl_diff, hl_diff;

   assign take_2 = !v2_ff || div_in_ready;

   always_comb begin
      x_ext = 25'(x1_ff);
      low_ext = 25'(slab_low_ff);
      high_ext = 25'(slab_high_ff);
      xl_diff = x_ext - low_ext;
      hl_diff = high_ext - low_ext;
      num2_in = '0;
      den2_in = RW'(1);
      if (norm_mode_ff) begin
         if (x1_ff < slab_low_ff) begin
            num2_in = '0;
         end else if (x1_ff > slab_high_ff) begin
            num2_in = RW'(1);
         end else if (slab_high_ff == slab_low_ff) begin
            num2_in = '0;
         end else begin
            num2_in = unsigned'(xl_diff);
            den2_in = unsigned'(hl_diff);
         end
      end else begin
         if (radius_ff == '0) begin
            num2_in = RW'(1);
         end else if (x1_ff[23]) begin
            num2_in = '0;
         end else if (x1_ff[22:0] >= radius_ff) begin
            num2_in = RW'(1);
         end else begin
            num2_in = RW'(x1_ff[22:0]);
            den2_in = RW'(radius_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (take_2) begin
         v2_ff <= v1_ff;
      end
      if (take_2) begin
         num2_ff <= num2_in;
         den2_ff <= den2_in;
         item2_ff <= item1_ff;
      end
   end

   // Divider stages.
   logic [QW-1:0]             div_quo;
   logic [scm_pkg::ITEM_W-1:0] div_pay;
   scm_pkg::item_type         div_item;

   scm_div #(
      .PAY_W(scm_pkg::ITEM_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .in_valid(v2_ff),
      .in_ready(div_in_ready),
      .in_num(num2_ff),
      .in_den(den2_ff),
      .in_pay(item2_ff),
      .out_valid(div_out_valid),
      .out_ready(take_p),
      .out_quo(div_quo),
      .out_pay(div_pay)
   );

   assign div_item = scm_pkg::item_type'(div_pay);

   // Stage P: segment, weight and memory addresses.
   logic              v_p_ff;
   scm_pkg::item_type item_p_ff;
   logic [SW-1:0]     seg_ff, seg_in;
   logic [QW-1:0]     w_ff, w_in;
   logic [AW-1:0]     a0_ff, a1_ff;
   logic [QW-1:0]     om;
   logic [QW+SW-1:0]  prod;
   logic [SW-1:0]     seg_raw;

   assign take_p = !v_p_ff || take_m;

   always_comb begin
      om = scm_pkg::ONE_Q16 - div_quo;
      prod = (QW+SW)'(om) * (QW+SW)'(s_seg);
      seg_raw = prod[scm_pkg::FRAC_W +: SW];
      if (seg_raw >= s_seg) begin
         seg_in = s_seg - SW'(1);
         w_in = scm_pkg::ONE_Q16;
      end else begin
         seg_in = seg_raw;
         w_in = {1'b0, prod[scm_pkg::FRAC_W-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_p_ff <= 1'b0;
      end else if (take_p) begin
         v_p_ff <= div_out_valid;
      end
      if (take_p) begin
         item_p_ff <= div_item;
         seg_ff <= seg_in;
         w_ff <= w_in;
         a0_ff <= pal_base + AW'(seg_in);
         a1_ff <= pal_base + AW'(seg_in) + AW'(1);
      end
   end

   // Stage M: palette memory; stop writes and stop reads share this stage.
   logic [23:0]   mem [DEPTH];
   logic          v_m_ff;
   logic [23:0]   lo_ff, hi_ff;
   logic [QW-1:0] w_m_ff;
   logic [23:0]   old_m_ff;
   logic [AW-1:0] waddr;
   logic          wr_ok;

   assign take_m = !v_m_ff || take_l;
   assign waddr = AW'(int'(item_p_ff.stop_palette) * MAX_STOPS + int'(item_p_ff.stop_index));
   assign wr_ok = (int'(item_p_ff.stop_palette) < NUM_PALETTES) &&
                  (int'(item_p_ff.stop_index) < MAX_STOPS);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_m_ff <= 1'b0;
      end else if (take_m) begin
         v_m_ff <= v_p_ff && (item_p_ff.op == scm_pkg::OP_MAP);
      end
      if (take_m && v_p_ff) begin
         if (item_p_ff.op == scm_pkg::OP_WRITE) begin
            if (wr_ok) begin
               mem[waddr] <= {item_p_ff.stop_red, item_p_ff.stop_green, item_p_ff.stop_blue};
            end
         end else begin
            lo_ff <= mem[a0_ff];
            hi_ff <= mem[a1_ff];
            w_m_ff <= w_ff;
            old_m_ff <= {item_p_ff.old_red, item_p_ff.old_green, item_p_ff.old_blue};
         end
      end
   end

   // Stage L: linear interpolation.
   function automatic logic [7:0] lerp8(logic [7:0] a, logic [7:0] b, logic [QW-1:0] w);
      logic [25:0] acc;
      acc = 26'(a) * 26'(scm_pkg::ONE_Q16 - w) + 26'(b) * 26'(w) + 26'd32768;
      return acc[23:16];
   endfunction

   logic        v_l_ff;
   logic [23:0] col_l_ff;
   logic [23:0] old_l_ff;

   assign take_l = !v_l_ff || take_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_l_ff <= 1'b0;
      end else if (take_l) begin
         v_l_ff <= v_m_ff;
      end
      if (take_l) begin
         col_l_ff <= {lerp8(lo_ff[23:16], hi_ff[23:16], w_m_ff),
                      lerp8(lo_ff[15:8], hi_ff[15:8], w_m_ff),
                      lerp8(lo_ff[7:0], hi_ff[7:0], w_m_ff)};
         old_l_ff <= old_m_ff;
      end
   end

   // Stage B: optional blend into the output register.
   function automatic logic [7:0] blend8(logic [7:0] c, logic [7:0] o, logic [8:0] a);
      logic [16:0] acc;
      acc = 17'(a) * 17'(c) + 17'(scm_pkg::ALPHA_ONE - a) * 17'(o) + 17'd128;
      return acc[15:8];
   endfunction

   logic        v_b_ff;
   logic [23:0] col_b_ff;

   assign take_b = !v_b_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_b_ff <= 1'b0;
      end else if (take_b) begin
         v_b_ff <= v_l_ff;
      end
      if (take_b) begin
         if (combine_enable_ff) begin
            col_b_ff <= {blend8(col_l_ff[23:16], old_l_ff[23:16], alpha_eff),
                         blend8(col_l_ff[15:8], old_l_ff[15:8], alpha_eff),
                         blend8(col_l_ff[7:0], old_l_ff[7:0], alpha_eff)};
         end else begin
            col_b_ff <= col_l_ff;
         end
      end
   end

   assign rsp_valid = v_b_ff;
   assign rsp_red = col_b_ff[23:16];
   assign rsp_green = col_b_ff[15:8];
   assign rsp_blue = col_b_ff[7:0];

   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      (v_p_ff && item_p_ff.op == scm_pkg::OP_MAP) |-> seg_ff < s_seg)
      else $error("segment beyond last stop");

   a_full_weight: assert property (@(posedge clock) disable iff (reset)
      (v_p_ff && item_p_ff.op == scm_pkg::OP_MAP && w_ff == scm_pkg::ONE_Q16)
      |-> seg_ff == s_seg - SW'(1))
      else $error("full weight outside last segment");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

// ===== rtl/scm_div.sv =====
// Pipelined restoring divider producing a Q1.16 fraction, one quotient bit per stage.
module scm_div #(
   parameter int PAY_W = scm_pkg::ITEM_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [scm_pkg::REM_W-1:0]  in_num,
   input  logic [scm_pkg::REM_W-1:0]  in_den,
   input  logic [PAY_W-1:0]           in_pay,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [scm_pkg::QUO_W-1:0]  out_quo,
   output logic [PAY_W-1:0]           out_pay
);

   localparam int QW = scm_pkg::QUO_W;
   localparam int RW = scm_pkg::REM_W;

   logic [RW-1:0]    r_ff [QW];
   logic [RW-1:0]    d_ff [QW];
   logic [QW-1:0]    q_ff [QW];
   logic [PAY_W-1:0] pay_ff [QW];
   logic [QW-1:0]    v_ff;
   logic [QW:0]      take;

   assign take[QW] = out_ready;

   genvar k;
   generate
      for (k = 0; k < QW; k++) begin : g_stage
         logic [RW-1:0]    src_r;
         logic [RW-1:0]    src_d;
         logic [QW-1:0]    src_q;
         logic [PAY_W-1:0] src_pay;
         logic             src_v;
         logic [RW:0]      t;
         logic             ge;
         logic [RW:0]      diff;
         logic [RW-1:0]    r_in;
         logic [QW-1:0]    q_in;

         if (k == 0) begin : g_first
            assign src_r = in_num;
            assign src_d = in_den;
            assign src_q = '0;
            assign src_pay = in_pay;
            assign src_v = in_valid;
            assign t = {1'b0, src_r};
         end else begin : g_next
            assign src_r = r_ff[k-1];
            assign src_d = d_ff[k-1];
            assign src_q = q_ff[k-1];
            assign src_pay = pay_ff[k-1];
            assign src_v = v_ff[k-1];
            assign t = {src_r, 1'b0};
         end

         assign take[k] = !v_ff[k] || take[k+1];

         always_comb begin
            diff = t - {1'b0, src_d};
            ge = (t >= {1'b0, src_d});
            r_in = ge ? diff[RW-1:0] : t[RW-1:0];
            q_in = src_q;
            q_in[QW-1-k] = ge;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (take[k]) begin
               v_ff[k] <= src_v;
            end
            if (take[k]) begin
               r_ff[k] <= r_in;
               d_ff[k] <= src_d;
               q_ff[k] <= q_in;
               pay_ff[k] <= src_pay;
            end
         end
      end
   endgenerate

   assign in_ready = take[0];
   assign out_valid = v_ff[QW-1];
   assign out_quo = q_ff[QW-1];
   assign out_pay = pay_ff[QW-1];

   a_quo_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_quo <= scm_pkg::ONE_Q16)
      else $error("quotient above one");

endmodule
